[sv/wbre_pkg.sv]
package wbre_pkg;

	localparam int ClassW = 5;

	localparam logic [ClassW-1:0] WB_OTHER     = 5'd0;
	localparam logic [ClassW-1:0] WB_CR        = 5'd1;
	localparam logic [ClassW-1:0] WB_LF        = 5'd2;
	localparam logic [ClassW-1:0] WB_NEWLINE   = 5'd3;
	localparam logic [ClassW-1:0] WB_EXTEND    = 5'd4;
	localparam logic [ClassW-1:0] WB_ZWJ       = 5'd5;
	localparam logic [ClassW-1:0] WB_RI        = 5'd6;
	localparam logic [ClassW-1:0] WB_FORMAT    = 5'd7;
	localparam logic [ClassW-1:0] WB_KATAKANA  = 5'd8;
	localparam logic [ClassW-1:0] WB_HEBREW    = 5'd9;
	localparam logic [ClassW-1:0] WB_ALETTER   = 5'd10;
	localparam logic [ClassW-1:0] WB_SQUOTE    = 5'd11;
	localparam logic [ClassW-1:0] WB_DQUOTE    = 5'd12;
	localparam logic [ClassW-1:0] WB_MIDNUMLET = 5'd13;
	localparam logic [ClassW-1:0] WB_MIDLETTER = 5'd14;
	localparam logic [ClassW-1:0] WB_MIDNUM    = 5'd15;
	localparam logic [ClassW-1:0] WB_NUMERIC   = 5'd16;
	localparam logic [ClassW-1:0] WB_EXTNUMLET = 5'd17;
	localparam logic [ClassW-1:0] WB_WSEGSPACE = 5'd18;

	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	typedef enum logic [1:0] {
		DEC_NONE  = 2'd0,
		DEC_KEEP  = 2'd1,
		DEC_BREAK = 2'd2
	} decision_t;

	// what the back end has to do with a queued transaction
	typedef enum logic [1:0] {
		OP_NONE,
		OP_BREAK,
		OP_PAIR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ClassW-1:0] bb;
		logic [ClassW-1:0] b;
		logic [ClassW-1:0] c;
		logic              parity;
	} job_t;

endpackage

[sv/word_boundary_rule_engine.sv]
// Word boundary rule engine: one transaction per code point class or end-of-text mark, and
// exactly one decision per transaction, in order. A new transaction is taken every cycle
// while full is low; the front end updates the class history and parity as it accepts, a
// two-entry queue holds classified transactions, and the back end evaluates the boundary
// rules into a single output register. Each decision passes through a queue slot and then the
// output register; full rises only after the queue and the output register are both occupied.
module word_boundary_rule_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        kind,
	input  logic                        start_of_text,
	input  logic [wbre_pkg::ClassW-1:0] word_class,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  decision
);
	import wbre_pkg::*;

	job_t front_job;
	job_t queue_job;
	logic accept;
	logic queue_empty;
	logic queue_take;

	assign accept = push && !full;

	wbre_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.kind          (kind),
		.start_of_text (start_of_text),
		.word_class    (word_class),
		.job           (front_job)
	);

	wbre_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_job),
		.rd_en   (queue_take),
		.rd_data (queue_job),
		.full    (full),
		.empty   (queue_empty)
	);

	wbre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_valid (!queue_empty),
		.job_take  (queue_take),
		.empty     (empty),
		.pop       (pop),
		.decision  (decision)
	);

endmodule

[sv/wbre_front.sv]
module wbre_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic                    kind,
	input  logic                    start_of_text,
	input  logic [wbre_pkg::ClassW-1:0] word_class,
	output wbre_pkg::job_t          job
);
	import wbre_pkg::*;

	logic [ClassW-1:0] cur_q;
	logic [ClassW-1:0] prev_q;
	logic              seen_q;
	logic              parity_q;

	always_comb begin
		job.op     = OP_NONE;
		job.bb     = prev_q;
		job.b      = cur_q;
		job.c      = word_class;
		job.parity = parity_q;
		if (kind) begin
			job.op = seen_q ? OP_BREAK : OP_NONE;
		end else if (!start_of_text && seen_q) begin
			job.op = OP_PAIR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= WB_OTHER;
			prev_q   <= WB_OTHER;
			seen_q   <= 1'b0;
			parity_q <= 1'b0;
		end else if (accept) begin
			if (kind) begin
				cur_q    <= WB_OTHER;
				prev_q   <= WB_OTHER;
				seen_q   <= 1'b0;
				parity_q <= 1'b0;
			end else if (start_of_text || !seen_q) begin
				// first code point of a text: drop history
				cur_q    <= word_class;
				prev_q   <= WB_OTHER;
				seen_q   <= 1'b1;
				parity_q <= 1'b0;
			end else begin
				prev_q   <= cur_q;
				cur_q    <= word_class;
				parity_q <= (cur_q == WB_RI && word_class == WB_RI) ? ~parity_q : 1'b0;
			end
		end
	end

endmodule

[sv/wbre_queue.sv]
module wbre_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  wbre_pkg::job_t wr_data,
	input  logic           rd_en,
	output wbre_pkg::job_t rd_data,
	output logic           full,
	output logic           empty
);
	import wbre_pkg::*;

	job_t                 slot_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] count_q;

	assign full    = (count_q == QueueCntW'(QueueDepth));
	assign empty   = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/wbre_back.sv]
module wbre_back (
	input  logic           clk,
	input  logic           arst_n,
	input  wbre_pkg::job_t job,
	input  logic           job_valid,
	output logic           job_take,
	output logic           empty,
	input  logic           pop,
	output logic [1:0]     decision
);
	import wbre_pkg::*;

	logic      out_valid_q;
	decision_t out_q;
	decision_t rule;
	logic      ah_bb, ah_b, ah_c;

	assign ah_bb = (job.bb inside {WB_ALETTER, WB_HEBREW});
	assign ah_b  = (job.b inside {WB_ALETTER, WB_HEBREW});
	assign ah_c  = (job.c inside {WB_ALETTER, WB_HEBREW});

	// first matching rule wins
	always_comb begin
		rule = DEC_BREAK;
		if (job.b == WB_CR && job.c == WB_LF) begin
			rule = DEC_KEEP;
		end else if ((job.b inside {WB_CR, WB_LF, WB_NEWLINE})
				|| (job.c inside {WB_CR, WB_LF, WB_NEWLINE})) begin
			rule = DEC_BREAK;
		end else if (job.b == WB_WSEGSPACE && job.c == WB_WSEGSPACE) begin
			rule = DEC_KEEP;
		end else if (ah_b && ah_c) begin
			rule = DEC_KEEP;
		end else if (ah_bb && (job.b inside {WB_MIDLETTER, WB_MIDNUMLET, WB_SQUOTE}) && ah_c) begin
			rule = DEC_KEEP;
		end else if (job.b == WB_HEBREW && job.c == WB_SQUOTE) begin
			rule = DEC_KEEP;
		end else if (job.bb == WB_HEBREW && job.b == WB_DQUOTE && job.c == WB_HEBREW) begin
			rule = DEC_KEEP;
		end else if ((job.b == WB_NUMERIC || ah_b) && (job.c == WB_NUMERIC || ah_c)) begin
			rule = DEC_KEEP;
		end else if (job.bb == WB_NUMERIC && (job.b inside {WB_MIDNUM, WB_MIDNUMLET, WB_SQUOTE})
				&& job.c == WB_NUMERIC) begin
			rule = DEC_KEEP;
		end else if (job.b == WB_KATAKANA && job.c == WB_KATAKANA) begin
			rule = DEC_KEEP;
		end else if ((ah_b || (job.b inside {WB_NUMERIC, WB_KATAKANA, WB_EXTNUMLET}))
				&& job.c == WB_EXTNUMLET) begin
			rule = DEC_KEEP;
		end else if (job.b == WB_EXTNUMLET && (ah_c || (job.c inside {WB_NUMERIC, WB_KATAKANA}))) begin
			rule = DEC_KEEP;
		end else if (job.b == WB_RI && job.c == WB_RI) begin
			rule = job.parity ? DEC_BREAK : DEC_KEEP;
		end
	end

	assign job_take = job_valid && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign decision = out_q;

	always_ff @(posedge clk) begin
		if (job_take) begin
			case (job.op)
				OP_NONE:  out_q <= DEC_NONE;
				OP_BREAK: out_q <= DEC_BREAK;
				OP_PAIR:  out_q <= rule;
				default:  out_q <= DEC_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (job_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
